/* sv/pal2c_pkg.sv */
// ============================================================================
// pal2c_pkg: shared types and constants for the two-colour block coder
// Pixel, colour and distance types, the pair table and the result record.
// ============================================================================
`default_nettype none

package pal2c_pkg;

    typedef logic [7:0]  idx_t;
    typedef logic [23:0] rgb_t;
    typedef logic [17:0] dist_t;

    // command carried in the input tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CODE = 1'b1;

    // distinct-index class of a block
    typedef enum logic [1:0] {
        NDC_ONE  = 2'd0,
        NDC_TWO  = 2'd1,
        NDC_MANY = 2'd2
    } ndc_t;

    localparam int NUM_PAIRS = 6;

    // pixel pairs: (TL,TR) (TL,BL) (TL,BR) (TR,BL) (TR,BR) (BL,BR)
    localparam logic [1:0] PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PAIR_B [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

    localparam logic [3:0] ODD_MARK  = 4'hF;
    localparam logic [3:0] EVEN_MARK = 4'h0;
    localparam logic [4:0] LEN_UNIFORM = 5'd11;
    localparam logic [4:0] LEN_TWO     = 5'd20;

    typedef struct packed {
        logic [3:0][7:0] px;
        logic            loaded;
        ndc_t            ndc;
    } meta_t;

    typedef struct packed {
        logic            is_uniform;
        logic [19:0]     code_bits;
        logic [4:0]      code_length;
        logic [3:0]      pixel_mask;
        idx_t            color0;
        idx_t            color1;
        logic [3:0][7:0] recon;
    } result_t;

endpackage

`default_nettype wire

/* sv/palette_two_color_block_coder_top.sv */
// ============================================================================
// palette_two_color_block_coder_top: 2x2 two-colour palette block coder
// Loads palette entries and codes 2x2 blocks of palette indices.
// ============================================================================
// A beat with tuser 0 loads one palette entry; a beat with tuser 1 codes one
// 2x2 block and yields one result beat at the output. One beat is taken
// every cycle: the palette RAM read, the three-stage distance pipeline and
// the two decision stages all advance together, and the whole pipeline
// holds only while a result sits unaccepted on the output. A code beat sees
// every load taken before it. Loads give no result.
`default_nettype none

module palette_two_color_block_coder_top #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // entry_index, red, green, blue, pixel_tl, pixel_tr, pixel_bl, pixel_br
    input  wire logic [63:0] s_axis_tdata,
    // command
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // code_bits, code_length, pixel_mask, color0, color1,
    // recon_tl, recon_tr, recon_bl, recon_br, zero fill
    output logic [79:0]      m_axis_tdata,
    // is_uniform
    output logic             m_axis_tuser
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic                    adv, acc, load_acc, code_acc, load_ok;
    logic                    loaded_reg;
    logic                    v1_reg;
    pal2c_pkg::meta_t        m1_reg, meta_in;
    logic [3:0]              inr_reg, inr_next;
    pal2c_pkg::rgb_t [3:0]   rd, col1;
    logic                    vdist;
    pal2c_pkg::meta_t        mdist;
    pal2c_pkg::dist_t [5:0]  ddist;
    pal2c_pkg::result_t      res;
    logic [3:0][7:0]         px;

    assign adv      = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign acc      = s_axis_tvalid && adv;
    assign load_acc = acc && (s_axis_tuser == pal2c_pkg::CMD_LOAD);
    assign code_acc = acc && (s_axis_tuser == pal2c_pkg::CMD_CODE);
    assign load_ok  = ({1'b0, s_axis_tdata[7:0]} < 9'(PALETTE_ENTRIES));

    always_comb begin
        logic [7:0] other;
        for (int k = 0; k < 4; k++) begin
            px[k]       = s_axis_tdata[32 + 8*k +: 8];
            inr_next[k] = ({1'b0, px[k]} < 9'(PALETTE_ENTRIES));
        end
        // first index in scan order that differs from top-left
        other = (px[1] != px[0]) ? px[1] : (px[2] != px[0]) ? px[2] : px[3];
        meta_in.px     = px;
        meta_in.loaded = loaded_reg;
        if (px[1] == px[0] && px[2] == px[0] && px[3] == px[0]) begin
            meta_in.ndc = pal2c_pkg::NDC_ONE;
        end else if ((px[1] == px[0] || px[1] == other)
                  && (px[2] == px[0] || px[2] == other)
                  && (px[3] == px[0] || px[3] == other)) begin
            meta_in.ndc = pal2c_pkg::NDC_TWO;
        end else begin
            meta_in.ndc = pal2c_pkg::NDC_MANY;
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_ram
        pal2c_pal_ram #(
            .DEPTH (PALETTE_ENTRIES),
            .AW    (AW)
        ) u_ram (
            .aclk  (aclk),
            .we    (load_acc && load_ok),
            .waddr (s_axis_tdata[AW-1:0]),
            .wdata ({s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]}),
            .re    (adv),
            .raddr (px[g][AW-1:0]),
            .rdata (rd[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= 1'b0;
            v1_reg     <= 1'b0;
        end else begin
            if (load_acc && load_ok) begin
                loaded_reg <= 1'b1;
            end
            if (adv) begin
                v1_reg <= code_acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_reg  <= meta_in;
            inr_reg <= inr_next;
        end
    end

    // out-of-range pixels read black
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            col1[k] = inr_reg[k] ? rd[k] : '0;
        end
    end

    pal2c_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v1_reg),
        .in_meta   (m1_reg),
        .in_col    (col1),
        .out_valid (vdist),
        .out_meta  (mdist),
        .out_dist  (ddist)
    );

    pal2c_decide u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (vdist),
        .in_meta   (mdist),
        .in_dist   (ddist),
        .out_valid (m_axis_tvalid),
        .out_res   (res)
    );

    assign m_axis_tuser = res.is_uniform;
    assign m_axis_tdata = {3'b000, res.recon[3], res.recon[2], res.recon[1], res.recon[0],
                           res.color1, res.color0, res.pixel_mask, res.code_length,
                           res.code_bits};

    a_len_matches_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser ? (res.code_length == pal2c_pkg::LEN_UNIFORM)
                                        : (res.code_length == pal2c_pkg::LEN_TWO)))
        else $error("code length does not match block kind");

    a_two_colour_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (res.pixel_mask != 4'd0))
        else $error("two-colour block with empty mask");

    a_uniform_recon: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> (res.color1 == 8'd0
            && res.recon[1] == res.color0 && res.recon[3] == res.color0))
        else $error("uniform block reconstruction wrong");

    a_loaded_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg |=> loaded_reg)
        else $error("palette loaded flag dropped");

endmodule

`default_nettype wire

/* sv/pal2c_pal_ram.sv */
// ============================================================================
// pal2c_pal_ram: palette RAM, one write port and one registered read port
// Holds 24-bit RGB entries; read data holds while the read enable is low.
// ============================================================================
`default_nettype none

module pal2c_pal_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire pal2c_pkg::rgb_t wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output pal2c_pkg::rgb_t    rdata
);

    pal2c_pkg::rgb_t mem [DEPTH];
    pal2c_pkg::rgb_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/pal2c_dist.sv */
// ============================================================================
// pal2c_dist: pairwise distance pipeline
// Three stages: component differences, squares, sum and metric select, for
// all six pixel pairs of a block.
// ============================================================================
`default_nettype none

module pal2c_dist (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire pal2c_pkg::meta_t     in_meta,
    input  wire pal2c_pkg::rgb_t [3:0] in_col,
    output logic                      out_valid,
    output pal2c_pkg::meta_t          out_meta,
    output pal2c_pkg::dist_t [5:0]    out_dist
);

    logic                  va_reg, vb_reg, vc_reg;
    pal2c_pkg::meta_t      ma_reg, mb_reg, mc_reg;
    logic [5:0][2:0][7:0]  diff_reg, diff_next;
    logic [5:0][7:0]       idxa_reg, idxa_next, idxb_reg;
    logic [5:0][2:0][15:0] sq_reg, sq_next;
    pal2c_pkg::dist_t [5:0] dist_reg, dist_next;

    always_comb begin
        for (int p = 0; p < pal2c_pkg::NUM_PAIRS; p++) begin
            for (int c = 0; c < 3; c++) begin
                logic [7:0] x, y;
                x = in_col[pal2c_pkg::PAIR_A[p]][c*8 +: 8];
                y = in_col[pal2c_pkg::PAIR_B[p]][c*8 +: 8];
                diff_next[p][c] = (x > y) ? (x - y) : (y - x);
            end
            idxa_next[p] = (in_meta.px[pal2c_pkg::PAIR_A[p]] > in_meta.px[pal2c_pkg::PAIR_B[p]])
                ? (in_meta.px[pal2c_pkg::PAIR_A[p]] - in_meta.px[pal2c_pkg::PAIR_B[p]])
                : (in_meta.px[pal2c_pkg::PAIR_B[p]] - in_meta.px[pal2c_pkg::PAIR_A[p]]);
        end
    end

    always_comb begin
        for (int p = 0; p < pal2c_pkg::NUM_PAIRS; p++) begin
            for (int c = 0; c < 3; c++) begin
                sq_next[p][c] = diff_reg[p][c] * diff_reg[p][c];
            end
        end
    end

    always_comb begin
        for (int p = 0; p < pal2c_pkg::NUM_PAIRS; p++) begin
            dist_next[p] = mb_reg.loaded
                ? (18'(sq_reg[p][0]) + 18'(sq_reg[p][1]) + 18'(sq_reg[p][2]))
                : 18'(idxb_reg[p]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ma_reg   <= in_meta;
            diff_reg <= diff_next;
            idxa_reg <= idxa_next;
            mb_reg   <= ma_reg;
            sq_reg   <= sq_next;
            idxb_reg <= idxa_reg;
            mc_reg   <= mb_reg;
            dist_reg <= dist_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_meta  = mc_reg;
    assign out_dist  = dist_reg;

endmodule

`default_nettype wire

/* sv/pal2c_decide.sv */
// ============================================================================
// pal2c_decide: colour choice, mask and code word
// Stage one picks the farthest pixel (color1 for NDC_MANY); stage two builds
// the mask, the code word and the reconstruction into the output register.
// ============================================================================
`default_nettype none

module pal2c_decide (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   adv,
    input  wire logic                   in_valid,
    input  wire pal2c_pkg::meta_t       in_meta,
    input  wire pal2c_pkg::dist_t [5:0] in_dist,
    output logic                        out_valid,
    output pal2c_pkg::result_t          out_res
);

    logic                   vd_reg, ve_reg;
    pal2c_pkg::meta_t       md_reg;
    pal2c_pkg::dist_t [5:0] dd_reg;
    logic [1:0]             sel_reg, sel_next;
    pal2c_pkg::result_t     res_reg, res_next;
    pal2c_pkg::dist_t [3:0][3:0] dm;

    // first maximum of the distances from top-left wins
    always_comb begin
        pal2c_pkg::dist_t best;
        best     = in_dist[0];
        sel_next = 2'd1;
        if (in_dist[1] > best) begin
            best     = in_dist[1];
            sel_next = 2'd2;
        end
        if (in_dist[2] > best) begin
            sel_next = 2'd3;
        end
    end

    always_comb begin
        dm = '0;
        for (int p = 0; p < pal2c_pkg::NUM_PAIRS; p++) begin
            dm[pal2c_pkg::PAIR_A[p]][pal2c_pkg::PAIR_B[p]] = dd_reg[p];
            dm[pal2c_pkg::PAIR_B[p]][pal2c_pkg::PAIR_A[p]] = dd_reg[p];
        end
    end

    always_comb begin
        logic [3:0]       mask;
        pal2c_pkg::idx_t  c0, c1;
        logic             uni;
        c0   = md_reg.px[0];
        c1   = md_reg.px[sel_reg];
        mask = '0;
        uni  = 1'b0;
        case (md_reg.ndc)
            pal2c_pkg::NDC_ONE: begin
                uni = 1'b1;
            end
            pal2c_pkg::NDC_TWO: begin
                for (int k = 0; k < 4; k++) begin
                    mask[k] = (md_reg.px[k] != c0);
                end
                c1 = (md_reg.px[1] != c0) ? md_reg.px[1]
                   : (md_reg.px[2] != c0) ? md_reg.px[2] : md_reg.px[3];
            end
            pal2c_pkg::NDC_MANY: begin
                // ties stay with color0
                for (int k = 0; k < 4; k++) begin
                    mask[k] = (dm[k][sel_reg] < dm[k][0]);
                end
                uni = (mask == 4'd0);
            end
            default: begin
                uni = 1'b1;
            end
        endcase

        res_next.is_uniform = uni;
        if (uni) begin
            res_next.code_bits   = 20'({c0[7:1],
                ((c0[0]) ? pal2c_pkg::ODD_MARK : pal2c_pkg::EVEN_MARK)});
            res_next.code_length = pal2c_pkg::LEN_UNIFORM;
            res_next.pixel_mask  = '0;
            res_next.color0      = c0;
            res_next.color1      = '0;
            for (int k = 0; k < 4; k++) begin
                res_next.recon[k] = c0;
            end
        end else begin
            res_next.code_bits   = {c1, c0, mask};
            res_next.code_length = pal2c_pkg::LEN_TWO;
            res_next.pixel_mask  = mask;
            res_next.color0      = c0;
            res_next.color1      = c1;
            for (int k = 0; k < 4; k++) begin
                res_next.recon[k] = mask[k] ? c1 : c0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else if (adv) begin
            vd_reg <= in_valid;
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            md_reg  <= in_meta;
            dd_reg  <= in_dist;
            sel_reg <= sel_next;
            res_reg <= res_next;
        end
    end

    assign out_valid = ve_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

/* test/pal2c_checker.sv */
// ----------------------------------------------------------------------------
// pal2c_checker: predictor and scoreboard for the two-colour block coder
// Watches both stream channels, computes the expected code of every block
// beat from its own palette copy and compares each result beat field by field.
// ----------------------------------------------------------------------------
module pal2c_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    output int          fail_count,
    output int          codes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [23:0]         pal_rgb [256];
    logic                pal_loaded;
    pal2c_pkg::result_t  code_queue [$];

    function automatic int unsigned colour_dist(logic [7:0] a, logic [7:0] b);
        logic [23:0] ca, cb;
        int unsigned acc;
        if (!pal_loaded)
            return (a > b) ? a - b : b - a;
        ca = pal_rgb[a];
        cb = pal_rgb[b];
        acc = 0;
        for (int c = 0; c < 3; c++) begin
            int dd;
            dd = int'(ca[c*8 +: 8]) - int'(cb[c*8 +: 8]);
            acc += dd * dd;
        end
        return acc;
    endfunction

    function automatic pal2c_pkg::result_t predict_block(logic [3:0][7:0] px);
        pal2c_pkg::result_t r;
        logic [7:0] seen [$];
        logic [7:0] c0, c1;
        logic [3:0] mask;
        int unsigned best, d;
        logic uni;
        for (int k = 0; k < 4; k++) begin
            bit found;
            found = 0;
            foreach (seen[j]) if (seen[j] == px[k]) found = 1;
            if (!found) seen.push_back(px[k]);
        end
        c0 = px[0];
        c1 = '0;
        mask = '0;
        if (seen.size() == 1) begin
            uni = 1;
        end else if (seen.size() == 2) begin
            c1 = seen[1];
            for (int k = 0; k < 4; k++) mask[k] = (px[k] != c0);
            uni = 0;
        end else begin
            best = colour_dist(c0, px[1]);
            c1 = px[1];
            for (int k = 2; k < 4; k++) begin
                d = colour_dist(c0, px[k]);
                if (d > best) begin
                    best = d;
                    c1 = px[k];
                end
            end
            for (int k = 0; k < 4; k++)
                mask[k] = colour_dist(px[k], c1) < colour_dist(px[k], c0);
            uni = (mask == 0);
        end
        r.is_uniform = uni;
        if (uni) begin
            r.code_bits = {9'd0, c0[7:1],
                           c0[0] ? pal2c_pkg::ODD_MARK : pal2c_pkg::EVEN_MARK};
            r.code_length = pal2c_pkg::LEN_UNIFORM;
            r.pixel_mask = '0;
            r.color0 = c0;
            r.color1 = '0;
            for (int k = 0; k < 4; k++) r.recon[k] = c0;
        end else begin
            r.code_bits = {c1, c0, mask};
            r.code_length = pal2c_pkg::LEN_TWO;
            r.pixel_mask = mask;
            r.color0 = c0;
            r.color1 = c1;
            for (int k = 0; k < 4; k++) r.recon[k] = mask[k] ? c1 : c0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        pal2c_pkg::result_t want;
        logic [3:0][7:0] px;
        if (!aresetn) begin
            pal_loaded = 0;
            code_queue.delete();
            fail_count = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == pal2c_pkg::CMD_LOAD) begin
                    pal_rgb[s_axis_tdata[7:0]] = s_axis_tdata[31:8];
                    pal_loaded = 1;
                end else begin
                    for (int k = 0; k < 4; k++) px[k] = s_axis_tdata[32 + 8*k +: 8];
                    code_queue.push_back(predict_block(px));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (code_queue.size() == 0) begin
                    report_mismatch("unexpected result beat", 0, 0);
                end else begin
                    want = code_queue.pop_front();
                    if (m_axis_tuser != want.is_uniform)
                        report_mismatch("is_uniform", m_axis_tuser, want.is_uniform);
                    if (m_axis_tdata[19:0] != want.code_bits)
                        report_mismatch("code_bits", m_axis_tdata[19:0], want.code_bits);
                    if (m_axis_tdata[24:20] != want.code_length)
                        report_mismatch("code_length", m_axis_tdata[24:20],
                                        want.code_length);
                    if (m_axis_tdata[28:25] != want.pixel_mask)
                        report_mismatch("pixel_mask", m_axis_tdata[28:25],
                                        want.pixel_mask);
                    if (m_axis_tdata[36:29] != want.color0)
                        report_mismatch("color0", m_axis_tdata[36:29], want.color0);
                    if (m_axis_tdata[44:37] != want.color1)
                        report_mismatch("color1", m_axis_tdata[44:37], want.color1);
                    for (int k = 0; k < 4; k++)
                        if (m_axis_tdata[45 + 8*k +: 8] != want.recon[k])
                            report_mismatch($sformatf("recon[%0d]", k),
                                            m_axis_tdata[45 + 8*k +: 8], want.recon[k]);
                end
            end
        end
        codes_pending = code_queue.size();
    end
endmodule

/* test/tb_palette_two_color_block_coder_top.sv */
// ----------------------------------------------------------------------------
// tb_palette_two_color_block_coder_top: stimulus for the block coder
// Codes blocks by index distance first, then loads a full palette and codes
// directed and random blocks under varying idle patterns and a long stall.
// ----------------------------------------------------------------------------
module tb_palette_two_color_block_coder_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          fail_count;
    int          codes_pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          recv_hold = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    palette_two_color_block_coder_top dut (.*);

    pal2c_checker checker_i (.*);

    // one beat, with random idle cycles ahead of it; tvalid stays up afterwards
    task automatic send_beat(logic cmd, logic [63:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic send_block(logic [7:0] tl, logic [7:0] tr, logic [7:0] bl,
                              logic [7:0] br);
        send_beat(pal2c_pkg::CMD_CODE, {br, bl, tr, tl, 32'($urandom)});
    endtask

    task automatic send_load(logic [7:0] e, logic [23:0] rgb);
        send_beat(pal2c_pkg::CMD_LOAD, {32'($urandom), rgb, e});
    endtask

    function automatic logic [7:0] pick(logic [3:0][7:0] set, int n);
        return set[$urandom_range(n - 1)];
    endfunction

    task automatic drain();
        s_axis_tvalid <= 0;
        while (codes_pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    always @(negedge aclk)
        m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [3:0][7:0] set;
        repeat (4) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // index-distance phase: no palette yet
        send_block(8'd0, 8'd0, 8'd0, 8'd0);
        send_block(8'd255, 8'd255, 8'd255, 8'd255);
        send_block(8'd7, 8'd7, 8'd7, 8'd7);
        send_block(8'd0, 8'd255, 8'd255, 8'd0);
        send_block(8'd255, 8'd0, 8'd255, 8'd255);
        send_block(8'd10, 8'd20, 8'd30, 8'd40);
        send_block(8'd100, 8'd90, 8'd110, 8'd50);
        send_block(8'd50, 8'd40, 8'd60, 8'd45);  // tie on distance: first wins
        send_block(8'd50, 8'd51, 8'd49, 8'd50);  // tie on distance again: first wins
        for (int i = 0; i < 60; i++)
            send_block(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        drain();

        // fill the whole palette so no unwritten entry is ever read
        for (int e = 0; e < 256; e++)
            send_load(e[7:0], (e == 3 || e == 4) ? 24'h123456 : 24'($urandom));
        send_load(8'd0, 24'h000000);
        send_load(8'd255, 24'hFFFFFF);
        send_block(8'd3, 8'd4, 8'd0, 8'd255);    // equal colours
        send_block(8'd3, 8'd4, 8'd4, 8'd3);
        send_block(8'd3, 8'd4, 8'd3, 8'd3);
        send_block(8'd0, 8'd255, 8'd1, 8'd254);
        send_block(8'd255, 8'd0, 8'd3, 8'd4);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 71 : 0;
            recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 24 : 0;
            for (int i = 0; i < 275; i++) begin
                for (int k = 0; k < 4; k++) set[k] = 8'($urandom);
                if (phase == 2 && i == 50) begin
                    fork
                        begin
                            recv_hold = 1;
                            repeat (60) @(negedge aclk);
                            recv_hold = 0;
                        end
                    join_none
                end
                case ($urandom_range(9))
                    0: send_load(8'($urandom), 24'($urandom));
                    1, 2: send_block(set[0], set[0], set[0], set[0]);
                    3, 4: send_block(pick(set, 2), pick(set, 2), pick(set, 2),
                                     pick(set, 2));
                    5, 6: send_block(pick(set, 3), pick(set, 3), pick(set, 3),
                                     pick(set, 3));
                    default: send_block(set[0], set[1], set[2], set[3]);
                endcase
            end
            drain();
        end

        if (fail_count == 0 && codes_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
